// File: design/differential_drive_odometry_macros.svh
// Assertion macros for the odometry block.
// Included by the top level; needs the clock and reset names of that scope.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_MACROS_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DDO_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("odometry check failed");

// Next-cycle implication, disabled during reset.
`define DDO_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("odometry check failed");

`endif

// File: design/ddo_pkg.sv
// Shared types and constants for the differential drive odometry block.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package ddo_pkg;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_WHEEL_RADIUS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRACK_WIDTH  = 2'd1;

   localparam logic [7:0] RADIUS_RESET = 8'd41;
   localparam logic [9:0] TRACK_RESET  = 10'd162;

   // Shared multiplier, divider and CORDIC widths
   localparam int MUL_A_W = 48;
   localparam int MUL_B_W = 46;
   localparam int PROD_W  = 96;
   localparam int DIV_W   = 42;
   localparam int QUO_W   = 48;
   localparam int CRD_W   = 34;

   localparam logic [63:0] PI_Q28     = 64'd843314857;
   localparam logic [63:0] K_FWD      = PI_Q28 * 64'd2500;
   localparam logic [63:0] K_YAW      = PI_Q28 * 64'd50000;
   localparam logic [63:0] K_HEAD     = 64'd2147483648;
   localparam logic [63:0] DIST_DIV   = 64'd14745600;
   localparam logic [63:0] ADV_BIAS   = 64'd536870912;
   localparam logic [63:0] CORDIC_GAIN_Q30 = 64'd652032874;

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b00000000001,
      ST_PREP   = 11'b00000000010,
      ST_MLOAD  = 11'b00000000100,
      ST_MUL    = 11'b00000001000,
      ST_DLOAD  = 11'b00000010000,
      ST_DIV    = 11'b00000100000,
      ST_DSTORE = 11'b00001000000,
      ST_CLOAD  = 11'b00010000000,
      ST_CORD   = 11'b00100000000,
      ST_ASTORE = 11'b01000000000,
      ST_DONE   = 11'b10000000000
   } ddo_state_type;

   typedef enum logic [2:0] {
      JOB_FWD  = 3'd0,
      JOB_YAW  = 3'd1,
      JOB_HEAD = 3'd2,
      JOB_DIST = 3'd3,
      JOB_ADVX = 3'd4,
      JOB_ADVY = 3'd5
   } ddo_job_type;

   typedef struct packed {
      logic        capture;
      logic        prep;
      logic        mul_load;
      logic        mul_step;
      logic        div_load;
      logic        div_step;
      logic        div_store;
      logic        cord_load;
      logic        cord_step;
      logic        adv_store;
      logic        rsp_load;
      ddo_job_type job;
   } ddo_cmd_type;

   typedef struct packed {
      logic mul_last;
      logic div_last;
      logic cord_last;
   } ddo_status_type;

   function automatic logic [31:0] atan_entry(input logic [4:0] idx);
      logic [31:0] val;
      case (idx)
         5'd0:  val = 32'h20000000;
         5'd1:  val = 32'h12E4051E;
         5'd2:  val = 32'h09FB385B;
         5'd3:  val = 32'h051111D4;
         5'd4:  val = 32'h028B0D43;
         5'd5:  val = 32'h0145D7E1;
         5'd6:  val = 32'h00A2F61E;
         5'd7:  val = 32'h00517C55;
         5'd8:  val = 32'h0028BE53;
         5'd9:  val = 32'h00145F2F;
         5'd10: val = 32'h000A2F98;
         5'd11: val = 32'h000517CC;
         5'd12: val = 32'h00028BE6;
         5'd13: val = 32'h000145F3;
         5'd14: val = 32'h0000A2FA;
         5'd15: val = 32'h0000517D;
         5'd16: val = 32'h000028BE;
         5'd17: val = 32'h0000145F;
         5'd18: val = 32'h00000A30;
         5'd19: val = 32'h00000518;
         5'd20: val = 32'h0000028C;
         5'd21: val = 32'h00000146;
         5'd22: val = 32'h000000A3;
         5'd23: val = 32'h00000051;
         5'd24: val = 32'h00000029;
         5'd25: val = 32'h00000014;
         5'd26: val = 32'h0000000A;
         5'd27: val = 32'h00000005;
         5'd28: val = 32'h00000003;
         5'd29: val = 32'h00000001;
         5'd30: val = 32'h00000001;
         default: val = 32'h00000000;
      endcase
      return val;
   endfunction

   // Signed saturation of a rounded magnitude
   function automatic logic [31:0] sat_mag(input logic neg, input logic ovf,
                                           input logic [QUO_W-1:0] q);
      logic [31:0] val;
      if (neg) begin
         if (ovf || (q >= 48'd2147483648)) val = 32'h80000000;
         else val = 32'd0 - q[31:0];
      end else begin
         if (ovf || (q > 48'd2147483647)) val = 32'h7FFFFFFF;
         else val = q[31:0];
      end
      return val;
   endfunction

endpackage

// File: design/ddo_ctrl.sv
// Sequencer for the odometry block: steps the shared datapath units.
// Depends on ddo_pkg for the state, job, command and status types.
`timescale 1ns / 1ps

module ddo_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  ddo_pkg::ddo_status_type status,
   output ddo_pkg::ddo_cmd_type    cmd
);
   import ddo_pkg::*;

   ddo_state_type state_ff, state_in;
   ddo_job_type   job_ff, job_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.job      = job_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            job_in   = JOB_FWD;
            state_in = ST_MLOAD;
         end
         ST_MLOAD: begin
            cmd.mul_load = 1'b1;
            state_in     = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
            if (status.mul_last) begin
               if (job_ff == JOB_ADVX || job_ff == JOB_ADVY) state_in = ST_ASTORE;
               else state_in = ST_DLOAD;
            end
         end
         ST_DLOAD: begin
            cmd.div_load = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = ST_DSTORE;
         end
         ST_DSTORE: begin
            cmd.div_store = 1'b1;
            case (job_ff)
               JOB_FWD:  begin job_in = JOB_YAW;  state_in = ST_MLOAD; end
               JOB_YAW:  begin job_in = JOB_HEAD; state_in = ST_MLOAD; end
               JOB_HEAD: begin job_in = JOB_DIST; state_in = ST_MLOAD; end
               default:  state_in = ST_CLOAD;
            endcase
         end
         ST_CLOAD: begin
            cmd.cord_load = 1'b1;
            state_in      = ST_CORD;
         end
         ST_CORD: begin
            cmd.cord_step = 1'b1;
            if (status.cord_last) begin
               job_in   = JOB_ADVX;
               state_in = ST_MLOAD;
            end
         end
         ST_ASTORE: begin
            cmd.adv_store = 1'b1;
            if (job_ff == JOB_ADVX) begin
               job_in   = JOB_ADVY;
               state_in = ST_MLOAD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         job_ff       <= JOB_FWD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         job_ff       <= job_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: design/ddo_datapath.sv
// Datapath of the odometry block: state, config registers, shift-add
// multiplier, restoring divider, CORDIC and output registers. Uses ddo_pkg.
`timescale 1ns / 1ps

module ddo_datapath #(
   parameter int CORDIC_STAGES    = 16,
   parameter int SAMPLE_PERIOD_US = 4000
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [ddo_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ddo_pkg::CSR_DATA_W-1:0]   csr_data,
   input  logic signed [31:0]               req_left_count,
   input  logic signed [31:0]               req_right_count,
   input  ddo_pkg::ddo_cmd_type             cmd,
   output ddo_pkg::ddo_status_type          status,
   output logic signed [31:0]               rsp_pos_x,
   output logic signed [31:0]               rsp_pos_y,
   output logic        [31:0]               rsp_heading_angle,
   output logic signed [31:0]               rsp_fwd_speed,
   output logic signed [31:0]               rsp_yaw_rate
);
   import ddo_pkg::*;

   localparam int CIW = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;
   localparam logic [63:0] FWD_DIV64 = 64'(SAMPLE_PERIOD_US) * 64'd36864;
   localparam logic [31:0] FWD_DIV   = FWD_DIV64[31:0];

   // config and persistent state
   logic [7:0]  radius_ff;
   logic [9:0]  track_ff;
   logic [31:0] prev_left_ff, prev_right_ff, heading_ff;
   logic [31:0] x_ff, y_ff, fwd_ff, yaw_ff;
   // per-item values
   logic        sum_neg_ff, diff_neg_ff;
   logic [32:0] abs_sum_ff, abs_diff_ff;
   logic [40:0] msum_ff, mdiff_ff;
   logic [DIV_W-1:0] yaw_div_ff;
   logic [17:0] dden_ff;
   logic [QUO_W-1:0] dist_ff;
   // multiplier
   logic [PROD_W-1:0]  acc_ff, a_sh_ff;
   logic [MUL_B_W-1:0] b_ff;
   logic [5:0]         mcnt_ff;
   // divider
   logic [PROD_W-1:0] num_ff;
   logic [DIV_W-1:0]  d_ff, rem_ff;
   logic [QUO_W-1:0]  q_ff;
   logic              ovf_ff;
   logic [6:0]        dcnt_ff;
   // CORDIC
   logic signed [CRD_W-1:0] cx_ff, cy_ff, cz_ff;
   logic [CIW-1:0]          ci_ff;
   logic                    flip_ff;

   // capture combinational terms
   logic [31:0] dl, dr;
   logic [32:0] sum33, diff33;
   assign dl     = req_left_count - prev_left_ff;
   assign dr     = req_right_count - prev_right_ff;
   assign sum33  = {dl[31], dl} + {dr[31], dr};
   assign diff33 = {dr[31], dr} - {dl[31], dl};

   logic [9:0] w_eff;
   assign w_eff = (track_ff == 10'd0) ? 10'd1 : track_ff;

   // multiplier operand selection
   logic [MUL_A_W-1:0] op_a;
   logic [MUL_B_W-1:0] op_b;
   logic [DIV_W-1:0]   op_d;
   logic [PROD_W-1:0]  op_bias;
   logic [CRD_W-1:0]   abs_cx, abs_cy;
   assign abs_cx = cx_ff[CRD_W-1] ? (~cx_ff + 1'b1) : cx_ff;
   assign abs_cy = cy_ff[CRD_W-1] ? (~cy_ff + 1'b1) : cy_ff;

   always_comb begin
      op_a = MUL_A_W'(msum_ff);
      op_b = K_FWD[MUL_B_W-1:0];
      op_d = DIV_W'(FWD_DIV);
      case (cmd.job)
         JOB_FWD: begin
            op_a = MUL_A_W'(msum_ff);
            op_b = K_FWD[MUL_B_W-1:0];
            op_d = DIV_W'(FWD_DIV);
         end
         JOB_YAW: begin
            op_a = MUL_A_W'(mdiff_ff);
            op_b = K_YAW[MUL_B_W-1:0];
            op_d = yaw_div_ff;
         end
         JOB_HEAD: begin
            op_a = MUL_A_W'(mdiff_ff);
            op_b = K_HEAD[MUL_B_W-1:0];
            op_d = DIV_W'(dden_ff);
         end
         JOB_DIST: begin
            op_a = MUL_A_W'(msum_ff);
            op_b = PI_Q28[MUL_B_W-1:0];
            op_d = DIST_DIV[DIV_W-1:0];
         end
         JOB_ADVX: begin
            op_a = dist_ff;
            op_b = MUL_B_W'(abs_cx);
         end
         JOB_ADVY: begin
            op_a = dist_ff;
            op_b = MUL_B_W'(abs_cy);
         end
         default: ;
      endcase
      // rounding bias rides in the accumulator
      if (cmd.job == JOB_ADVX || cmd.job == JOB_ADVY) op_bias = PROD_W'(ADV_BIAS);
      else op_bias = PROD_W'(op_d >> 1);
   end

   // divider step
   logic [DIV_W:0] rem_sh;
   logic           ge;
   assign rem_sh = {rem_ff, num_ff[PROD_W-1]};
   assign ge     = (rem_sh >= {1'b0, d_ff});

   // CORDIC step
   logic signed [CRD_W-1:0] dx, dy, at;
   assign dx = cy_ff >>> ci_ff;
   assign dy = cx_ff >>> ci_ff;
   assign at = CRD_W'(atan_entry(5'(ci_ff)));

   logic [1:0]  quad;
   logic [31:0] ang;
   assign quad = heading_ff[31:30];
   assign ang  = (quad == 2'd1 || quad == 2'd2) ? heading_ff + 32'h80000000 : heading_ff;

   // heading step
   logic [31:0] hd;
   assign hd = diff_neg_ff ? (32'd0 - q_ff[31:0]) : q_ff[31:0];

   // position step: acc +/- rounded product, saturating
   logic [48:0] mag;
   logic        trig_neg, adv_neg;
   logic [31:0] acc_sel, adv_res;
   logic [50:0] acc51, mag51;
   logic signed [50:0] s51;
   assign mag = acc_ff[78:30];
   always_comb begin
      if (cmd.job == JOB_ADVX) begin
         acc_sel  = x_ff;
         trig_neg = flip_ff ? (!cx_ff[CRD_W-1] && cx_ff != '0) : cx_ff[CRD_W-1];
      end else begin
         acc_sel  = y_ff;
         trig_neg = flip_ff ? (!cy_ff[CRD_W-1] && cy_ff != '0) : cy_ff[CRD_W-1];
      end
      adv_neg = sum_neg_ff ^ trig_neg;
      acc51   = {{19{acc_sel[31]}}, acc_sel};
      mag51   = {2'b00, mag};
      s51     = $signed(adv_neg ? (acc51 - mag51) : (acc51 + mag51));
      if (s51 > 51'sd2147483647) adv_res = 32'h7FFFFFFF;
      else if (s51 < -51'sd2147483648) adv_res = 32'h80000000;
      else adv_res = s51[31:0];
   end

   assign status.mul_last  = (mcnt_ff == 6'(MUL_B_W - 1));
   assign status.div_last  = (dcnt_ff == 7'(PROD_W - 1));
   assign status.cord_last = (ci_ff == CIW'(CORDIC_STAGES - 1));

   // control-relevant state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff     <= RADIUS_RESET;
         track_ff      <= TRACK_RESET;
         prev_left_ff  <= 32'd0;
         prev_right_ff <= 32'd0;
         heading_ff    <= 32'd0;
         x_ff          <= 32'd0;
         y_ff          <= 32'd0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_WHEEL_RADIUS: radius_ff <= csr_data[7:0];
               CSR_TRACK_WIDTH:  track_ff  <= csr_data[9:0];
               default: ;
            endcase
         end
         if (cmd.capture) begin
            prev_left_ff  <= req_left_count;
            prev_right_ff <= req_right_count;
         end
         if (cmd.div_store && cmd.job == JOB_HEAD) heading_ff <= heading_ff + hd;
         if (cmd.adv_store) begin
            if (cmd.job == JOB_ADVX) x_ff <= adv_res;
            else y_ff <= adv_res;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sum_neg_ff  <= sum33[32];
         diff_neg_ff <= diff33[32];
         abs_sum_ff  <= sum33[32] ? (33'd0 - sum33) : sum33;
         abs_diff_ff <= diff33[32] ? (33'd0 - diff33) : diff33;
      end
      if (cmd.prep) begin
         msum_ff    <= 41'(abs_sum_ff) * 41'(radius_ff);
         mdiff_ff   <= 41'(abs_diff_ff) * 41'(radius_ff);
         yaw_div_ff <= DIV_W'(w_eff) * DIV_W'(FWD_DIV);
         dden_ff    <= 18'(w_eff) * 18'd180;
      end
      if (cmd.mul_load) begin
         acc_ff  <= op_bias;
         a_sh_ff <= PROD_W'(op_a);
         b_ff    <= op_b;
         d_ff    <= op_d;
         mcnt_ff <= 6'd0;
      end else if (cmd.mul_step) begin
         if (b_ff[0]) acc_ff <= acc_ff + a_sh_ff;
         a_sh_ff <= a_sh_ff << 1;
         b_ff    <= b_ff >> 1;
         mcnt_ff <= mcnt_ff + 6'd1;
      end
      if (cmd.div_load) begin
         num_ff  <= acc_ff;
         rem_ff  <= '0;
         q_ff    <= '0;
         ovf_ff  <= 1'b0;
         dcnt_ff <= 7'd0;
      end else if (cmd.div_step) begin
         rem_ff  <= ge ? DIV_W'(rem_sh - {1'b0, d_ff}) : DIV_W'(rem_sh);
         num_ff  <= num_ff << 1;
         q_ff    <= {q_ff[QUO_W-2:0], ge};
         ovf_ff  <= ovf_ff | q_ff[QUO_W-1];
         dcnt_ff <= dcnt_ff + 7'd1;
      end
      if (cmd.div_store) begin
         case (cmd.job)
            JOB_FWD:  fwd_ff  <= sat_mag(sum_neg_ff, ovf_ff, q_ff);
            JOB_YAW:  yaw_ff  <= sat_mag(diff_neg_ff, ovf_ff, q_ff);
            JOB_DIST: dist_ff <= q_ff;
            default: ;
         endcase
      end
      if (cmd.cord_load) begin
         flip_ff <= (quad == 2'd1 || quad == 2'd2);
         cx_ff   <= CRD_W'(CORDIC_GAIN_Q30);
         cy_ff   <= '0;
         cz_ff   <= {{(CRD_W-32){ang[31]}}, ang};
         ci_ff   <= '0;
      end else if (cmd.cord_step) begin
         if (!cz_ff[CRD_W-1]) begin
            cx_ff <= cx_ff - dx;
            cy_ff <= cy_ff + dy;
            cz_ff <= cz_ff - at;
         end else begin
            cx_ff <= cx_ff + dx;
            cy_ff <= cy_ff - dy;
            cz_ff <= cz_ff + at;
         end
         ci_ff <= ci_ff + 1'b1;
      end
      if (cmd.rsp_load) begin
         rsp_pos_x         <= x_ff;
         rsp_pos_y         <= y_ff;
         rsp_heading_angle <= heading_ff;
         rsp_fwd_speed     <= fwd_ff;
         rsp_yaw_rate      <= yaw_ff;
      end
   end

endmodule

// File: design/differential_drive_odometry.sv
// Top level of the differential drive odometry block.
// Instantiates ddo_ctrl and ddo_datapath; uses ddo_pkg and the assertion macros.
//
//   channel | ports  | direction | content
//   --------+--------+-----------+---------------------------------------------
//   req     | req_*  | in        | left_count, right_count (absolute, degrees)
//   rsp     | rsp_*  | out       | pos_x, pos_y, heading_angle, fwd_speed, yaw_rate
//   csr     | csr_*  | in        | index 0 wheel radius mm, index 1 track width mm
//
// The bit-serial shift-add multiplier works on MB = 46 multiplier bits and
// the restoring divider on ND = 96 divider bits. The multiplier is shared
// by all four quotients and both position updates, the divider by the four
// quotients; the CORDIC runs CORDIC_STAGES stages, 16 by default.
// Reset restores the config defaults and zeroes counts, heading and position.
// A result waiting on rsp does not block the next transfer on req; the block
// holds its finished result internally until the rsp register frees.
`timescale 1ns / 1ps
`include "differential_drive_odometry_macros.svh"

module differential_drive_odometry #(
   parameter int CORDIC_STAGES    = 16,
   parameter int SAMPLE_PERIOD_US = 4000
) (
   input  logic                           clock,
   input  logic                           reset,
   // configuration writes
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ddo_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ddo_pkg::CSR_DATA_W-1:0] csr_data,
   // encoder samples
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [31:0]             req_left_count,
   input  logic signed [31:0]             req_right_count,
   // pose and speed results
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [31:0]             rsp_pos_x,
   output logic signed [31:0]             rsp_pos_y,
   output logic        [31:0]             rsp_heading_angle,
   output logic signed [31:0]             rsp_fwd_speed,
   output logic signed [31:0]             rsp_yaw_rate
);
   import ddo_pkg::*;

   ddo_cmd_type    cmd;
   ddo_status_type status;

   // config writes go straight into the config registers, so always take the transfer
   assign csr_ready = 1'b1;

   ddo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ddo_datapath #(
      .CORDIC_STAGES    (CORDIC_STAGES),
      .SAMPLE_PERIOD_US (SAMPLE_PERIOD_US)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_left_count    (req_left_count),
      .req_right_count   (req_right_count),
      .cmd               (cmd),
      .status            (status),
      .rsp_pos_x         (rsp_pos_x),
      .rsp_pos_y         (rsp_pos_y),
      .rsp_heading_angle (rsp_heading_angle),
      .rsp_fwd_speed     (rsp_fwd_speed),
      .rsp_yaw_rate      (rsp_yaw_rate)
   );

   // a sample transfer starts work, so the port closes next cycle
   `DDO_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
   // capture only on a real transfer
   `DDO_ASSERT_NOW(a_capture_on_accept, cmd.capture, req_valid && req_ready)
   // never overwrite a result that has not been taken
   `DDO_ASSERT_NOW(a_no_overwrite, cmd.rsp_load, !rsp_valid || rsp_ready)

endmodule
